// ----- design/srisc_pkg.sv -----
// Package for the SimpleRISC execute core: opcodes, widths, helpers.
// No dependencies.
package srisc_pkg;

    localparam int MEM_WORDS_DEF = 4096;
    localparam int REG_COUNT_DEF = 16;
    localparam int XLEN          = 32;
    localparam int BASE_W        = 14;
    localparam logic [BASE_W-1:0] DATA_BASE_RST = 14'd4000;
    localparam logic [XLEN-1:0]   HALT_WORD     = 32'h0000_00ff;
    localparam logic [3:0]        SP_REG        = 4'd14;
    localparam logic [3:0]        LINK_REG      = 4'd15;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_SUB  = 5'd1;
    localparam logic [4:0] OP_MUL  = 5'd2;
    localparam logic [4:0] OP_DIV  = 5'd3;
    localparam logic [4:0] OP_MOD  = 5'd4;
    localparam logic [4:0] OP_CMP  = 5'd5;
    localparam logic [4:0] OP_AND  = 5'd6;
    localparam logic [4:0] OP_OR   = 5'd7;
    localparam logic [4:0] OP_NOT  = 5'd8;
    localparam logic [4:0] OP_MOV  = 5'd9;
    localparam logic [4:0] OP_LSL  = 5'd10;
    localparam logic [4:0] OP_LSR  = 5'd11;
    localparam logic [4:0] OP_ASR  = 5'd12;
    localparam logic [4:0] OP_LD   = 5'd14;
    localparam logic [4:0] OP_ST   = 5'd15;
    localparam logic [4:0] OP_BEQ  = 5'd16;
    localparam logic [4:0] OP_BGT  = 5'd17;
    localparam logic [4:0] OP_B    = 5'd18;
    localparam logic [4:0] OP_CALL = 5'd19;
    localparam logic [4:0] OP_RET  = 5'd20;

    // immediate with its 2-bit modifier
    function automatic logic [XLEN-1:0] make_imm(input logic [XLEN-1:0] w);
        logic [XLEN-1:0] r;
        unique case (w[17:16])
            2'd0:    r = {{16{w[15]}}, w[15:0]};
            2'd1:    r = {16'd0, w[15:0]};
            2'd2:    r = {w[15:0], 16'd0};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/srisc_if.sv -----
// Valid/ready channel interface carrying one item of type T.
// Depends on nothing.
interface srisc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/srisc_ram.sv -----
// Generic single-port RAM with registered read.
// Depends on nothing.
module srisc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- design/srisc_alu.sv -----
// Shared arithmetic unit: combinational ops plus an iterative unsigned divider.
// Depends on srisc_pkg.
module srisc_alu (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [4:0]             op,
    input  logic [31:0]            a,
    input  logic [31:0]            b,
    output logic                   done,
    output logic [31:0]            result,
    output logic                   eq,
    output logic                   gt
);
    import srisc_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] div_reg, div_next;
    logic [32:0] trial;
    logic        is_div;
    logic [31:0] mul_res;

    assign is_div  = (op == OP_DIV) || (op == OP_MOD);
    assign mul_res = a * b;
    assign trial   = {rem_reg[31:0], quo_reg[31]} - {1'b0, div_reg};
    assign eq      = (a == b);
    assign gt      = ($signed(a) > $signed(b));

    // restoring divider, one quotient bit a cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start && is_div)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            quo_next  = a;
            rem_next  = '0;
            div_next  = b;
        end
        else if (busy_reg)
        begin
            if (trial[32])
            begin
                rem_next = {rem_reg[31:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    // result select; divide results valid once the iteration ends
    // (a zero divisor leaves all ones in the quotient and the dividend in the remainder)
    always_comb
    begin
        done   = 1'b1;
        result = '0;
        unique case (op)
            OP_ADD:  result = a + b;
            OP_SUB:  result = a - b;
            OP_MUL:  result = mul_res;
            OP_AND:  result = a & b;
            OP_OR:   result = a | b;
            OP_NOT:  result = ~b;
            OP_MOV:  result = b;
            OP_LSL:  result = a << b[4:0];
            OP_LSR:  result = a >> b[4:0];
            OP_ASR:  result = $unsigned($signed(a) >>> b[4:0]);
            OP_LD,
            OP_ST:   result = a + b;
            OP_DIV:
            begin
                done   = !busy_reg && !start;
                result = (div_reg == '0) ? '1 : quo_reg;
            end
            OP_MOD:
            begin
                done   = !busy_reg && !start;
                result = rem_reg[31:0];
            end
            default: result = '0;
        endcase
    end
endmodule

// ----- design/risc_instruction_execute_core.sv -----
// Top level of the SimpleRISC execute core: sequencer, register file, flags.
// Depends on srisc_pkg, srisc_if, srisc_alu, srisc_ram.
//
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------
//  in_ch     | sink      | instr_word, instr_pc
//  out_ch    | source    | next_pc, taken, wb_enable, wb_index, wb_value, halted
//  cfg       | write     | data_base (14 bits)
//
// Most instructions pass from accept through the execute state to the output
// state; loads add a memory state for the RAM read, and div and mod wait in
// the execute state for the 32-step shared divider. The block accepts one item
// at a time and holds its result until taken. Reset clears the flags and the
// registers save the stack pointer, set to MEM_WORDS * 4; data memory is cleared
// by a sweep of MEM_WORDS words after reset, during which no item is accepted.
module risc_instruction_execute_core #(
    parameter int MEM_WORDS = srisc_pkg::MEM_WORDS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    srisc_if.sink                        in_ch,
    srisc_if.source                      out_ch,
    input  logic                         cfg_we,
    input  logic [srisc_pkg::BASE_W-1:0] cfg_wdata
);
    import srisc_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_MEM  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     clr_reg;
    logic [BASE_W-1:0] base_reg;
    logic [31:0]       regs_reg [REG_COUNT_DEF];
    logic              feq_reg, fgt_reg;
    logic [31:0]       w_reg, pc_reg, a_reg, b_reg, imm_reg;
    logic [31:0]       res_next_pc_reg, res_wbv_reg;
    logic              res_taken_reg, res_wbe_reg, res_halt_reg;
    logic [3:0]        res_wbi_reg;

    logic [4:0]  op;
    logic [3:0]  rd, rs1;
    logic        alu_start, alu_done, alu_eq, alu_gt;
    logic [31:0] alu_res, target, off, addr_sum;
    logic [31:0] in_b;
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0] ram_wdata, ram_rdata;

    assign op  = w_reg[31:27];
    assign rd  = w_reg[25:22];
    assign rs1 = w_reg[21:18];
    assign off = {{5{w_reg[26]}}, w_reg[26:0]};
    assign target = pc_reg + {off[29:0], 2'b00};
    assign alu_start = (state_reg == S_IDLE) && in_ch.valid;

    // operand B of the waiting item
    assign in_b = in_ch.data.instr_word[26] ? make_imm(in_ch.data.instr_word)
                                            : regs_reg[in_ch.data.instr_word[17:14]];

    srisc_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     ((state_reg == S_IDLE) ? in_ch.data.instr_word[31:27] : op),
        .a      ((state_reg == S_IDLE) ? regs_reg[in_ch.data.instr_word[21:18]] : a_reg),
        .b      ((state_reg == S_IDLE) ? in_b : b_reg),
        .done   (alu_done),
        .result (alu_res),
        .eq     (alu_eq),
        .gt     (alu_gt)
    );

    function automatic logic res_wbe_next();
        logic r;
        r = 1'b0;
        if (w_reg != HALT_WORD)
        begin
            r = (op <= OP_ASR && op != OP_CMP) || op == OP_LD || op == OP_CALL;
        end
        return r;
    endfunction

    function automatic logic [31:0] wbv_now();
        logic [31:0] r;
        r = alu_res;
        if (op == OP_LD) r = ram_rdata;
        else if (op == OP_CALL) r = pc_reg + 32'd4;
        return r;
    endfunction

    // memory address: st uses the immediate, ld uses B
    always_comb
    begin
        addr_sum = a_reg + ((op == OP_ST) ? imm_reg : b_reg);
        if (rs1 != SP_REG)
        begin
            addr_sum = addr_sum + {18'd0, base_reg};
        end
        ram_we    = 1'b0;
        ram_addr  = addr_sum[AW+1:2];
        ram_wdata = regs_reg[rd];
        if (state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_EXEC && op == OP_ST)
        begin
            ram_we = 1'b1;
        end
    end

    srisc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data.next_pc   = res_next_pc_reg;
    assign out_ch.data.taken     = res_taken_reg;
    assign out_ch.data.wb_enable = res_wbe_reg;
    assign out_ch.data.wb_index  = res_wbi_reg;
    assign out_ch.data.wb_value  = res_wbv_reg;
    assign out_ch.data.halted    = res_halt_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (clr_reg == AW'(MEM_WORDS - 1)) state_next = S_IDLE;
            S_IDLE: if (in_ch.valid) state_next = S_EXEC;
            S_EXEC:
            begin
                if (w_reg == HALT_WORD) state_next = S_OUT;
                else if (op == OP_LD) state_next = S_MEM;
                else if (alu_done) state_next = S_OUT;
            end
            S_MEM:  state_next = S_OUT;
            S_OUT:  if (out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            base_reg  <= DATA_BASE_RST;
            feq_reg   <= 1'b0;
            fgt_reg   <= 1'b0;
            for (int i = 0; i < REG_COUNT_DEF; i++)
            begin
                regs_reg[i] <= (i == int'(SP_REG)) ? 32'(MEM_WORDS * 4) : 32'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (state_reg == S_EXEC && w_reg != HALT_WORD && op == OP_CMP)
            begin
                feq_reg <= alu_eq;
                fgt_reg <= alu_gt;
            end
            if (state_next == S_OUT && state_reg != S_OUT && res_wbe_next())
            begin
                regs_reg[(op == OP_CALL) ? LINK_REG : rd] <= wbv_now();
            end
        end
    end

    // payload capture and result build
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            w_reg   <= in_ch.data.instr_word;
            pc_reg  <= in_ch.data.instr_pc;
            imm_reg <= make_imm(in_ch.data.instr_word);
            a_reg   <= regs_reg[in_ch.data.instr_word[21:18]];
            b_reg   <= in_b;
        end
        if (state_next == S_OUT && state_reg != S_OUT)
        begin
            res_halt_reg    <= (w_reg == HALT_WORD);
            res_wbe_reg     <= res_wbe_next();
            res_wbi_reg     <= res_wbe_next() ? ((op == OP_CALL) ? LINK_REG : rd) : 4'd0;
            res_wbv_reg     <= res_wbe_next() ? wbv_now() : 32'd0;
            res_taken_reg   <= 1'b0;
            res_next_pc_reg <= pc_reg + 32'd4;
            if (w_reg == HALT_WORD)
            begin
                res_next_pc_reg <= pc_reg;
            end
            else if ((op == OP_BEQ && feq_reg) || (op == OP_BGT && fgt_reg)
                     || op == OP_B || op == OP_CALL)
            begin
                res_taken_reg   <= 1'b1;
                res_next_pc_reg <= target;
            end
            else if (op == OP_RET)
            begin
                res_taken_reg   <= 1'b1;
                res_next_pc_reg <= regs_reg[LINK_REG];
            end
        end
    end
endmodule
